// File: rtl/button_telegram_sender_core_defines.svh
// assertion macros for the button telegram sender checker
// no dependencies; included by the checker file only
`ifndef BUTTON_TELEGRAM_SENDER_CORE_DEFINES_SVH
`define BUTTON_TELEGRAM_SENDER_CORE_DEFINES_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bts_pkg.sv
// shared types, constants and the telegram framing function
// no dependencies; used by every module of the button telegram sender
package bts_pkg;

	localparam int FRAME_MAX = 7;
	localparam int CNT_W     = 3;

	localparam logic [7:0] FRAME_STX       = 8'h02;
	localparam logic [7:0] FRAME_ESC       = 8'h1B;
	localparam logic [7:0] CHECK_SEED      = 8'h55;
	localparam logic [7:0] STARTUP_PAYLOAD = 8'hFF;

	localparam logic [7:0] RST_ADDRESS   = 8'd0;
	localparam logic [7:0] RST_TIMEOUT_S = 8'd8;
	localparam logic [3:0] RST_REPEAT    = 4'd3;
	localparam logic [7:0] RST_TPS       = 8'd61;
	localparam logic [7:0] RST_MS_TICK   = 8'd16;
	localparam logic [7:0] RST_STEP_MS   = 8'd100;

	typedef enum logic [2:0] {
		REG_ADDRESS   = 3'd0,
		REG_TIMEOUT_S = 3'd1,
		REG_REPEAT    = 3'd2,
		REG_TPS       = 3'd3,
		REG_MS_TICK   = 3'd4,
		REG_STEP_MS   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  module_address;
		logic [7:0]  send_timeout_s;
		logic [3:0]  repeat_ticks;
		logic [7:0]  ticks_per_second;
		logic [7:0]  ms_per_tick;
		logic [7:0]  startup_step_ms;
		logic [15:0] startup_limit;
	} cfg_t;

	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} frame_t;

	function automatic frame_t build_frame(input logic [7:0] addr, input logic [7:0] payload);
		frame_t           f;
		logic [7:0]       sum;
		logic [CNT_W-1:0] pos;
		logic [2:0][7:0]  fld;
		sum     = CHECK_SEED + FRAME_STX + addr + payload;
		f.bytes = '0;
		f.bytes[0] = FRAME_STX;
		pos    = 3'd1;
		fld[0] = addr;
		fld[1] = payload;
		fld[2] = sum;
		for (int i = 0; i < 3; i++) begin
			if (fld[i] == FRAME_STX || fld[i] == FRAME_ESC) begin
				f.bytes[pos]        = FRAME_ESC;
				f.bytes[pos + 3'd1] = ~fld[i];
				pos = pos + 3'd2;
			end else begin
				f.bytes[pos] = fld[i];
				pos = pos + 3'd1;
			end
		end
		f.count = pos;
		return f;
	endfunction

endpackage

// File: rtl/bts_regs.sv
// configuration register file with precomputed startup threshold
// depends on bts_pkg
module bts_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output bts_pkg::cfg_t        cfg
);

	logic [7:0]  address_q;
	logic [7:0]  timeout_q;
	logic [3:0]  repeat_q;
	logic [7:0]  tps_q;
	logic [7:0]  ms_tick_q;
	logic [7:0]  step_q;
	logic [15:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= bts_pkg::RST_ADDRESS;
			timeout_q <= bts_pkg::RST_TIMEOUT_S;
			repeat_q  <= bts_pkg::RST_REPEAT;
			tps_q     <= bts_pkg::RST_TPS;
			ms_tick_q <= bts_pkg::RST_MS_TICK;
			step_q    <= bts_pkg::RST_STEP_MS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bts_pkg::cfg_idx_t'(cfg_index))
				bts_pkg::REG_ADDRESS:   address_q <= cfg_data;
				bts_pkg::REG_TIMEOUT_S: timeout_q <= cfg_data;
				bts_pkg::REG_REPEAT:    repeat_q  <= cfg_data[3:0];
				bts_pkg::REG_TPS:       tps_q     <= cfg_data;
				bts_pkg::REG_MS_TICK:   ms_tick_q <= cfg_data;
				bts_pkg::REG_STEP_MS:   step_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// startup threshold, address times step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else begin
			limit_q <= {8'h00, address_q} * {8'h00, step_q};
		end
	end

	assign cfg.module_address   = address_q;
	assign cfg.send_timeout_s   = timeout_q;
	assign cfg.repeat_ticks     = repeat_q;
	assign cfg.ticks_per_second = tps_q;
	assign cfg.ms_per_tick      = ms_tick_q;
	assign cfg.startup_step_ms  = step_q;
	assign cfg.startup_limit    = limit_q;

endmodule

// File: rtl/bts_tick.sv
// tick input register, timekeeping and press state, telegram framing
// depends on bts_pkg
module bts_tick (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bts_pkg::cfg_t         cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            buttons_n,
	output bts_pkg::frame_t       frm,
	output logic                  frm_load,
	input  logic                  frm_free
);

	logic        valid_s1;
	logic [1:0]  buttons_s1;

	logic        startup_q;
	logic [15:0] elapsed_q;
	logic [7:0]  tis_q;
	logic [7:0]  sec_q;
	logic        held_q;
	logic [7:0]  start_q;
	logic [3:0]  phase_q;

	logic        startup_n;
	logic [15:0] elapsed_n;
	logic [7:0]  tis_inc;
	logic [7:0]  tis_n;
	logic [7:0]  sec_n;
	logic        held_n;
	logic [7:0]  start_n;
	logic [3:0]  phase_n;

	logic [1:0]  pressed;
	logic [7:0]  start_sel;
	logic [3:0]  phase_sel;
	logic [4:0]  phase_inc;
	logic [3:0]  period;
	logic        send;
	logic [7:0]  payload;
	logic        adv;

	always_comb begin
		pressed   = ~buttons_s1;
		elapsed_n = elapsed_q + {8'h00, cfg.ms_per_tick};
		tis_inc   = tis_q + 8'd1;
		if (tis_inc >= cfg.ticks_per_second) begin
			tis_n = '0;
			sec_n = sec_q + 8'd1;
		end else begin
			tis_n = tis_inc;
			sec_n = sec_q;
		end
		startup_n = startup_q;
		held_n    = held_q;
		start_n   = start_q;
		phase_n   = phase_q;
		start_sel = held_q ? start_q : sec_n;
		phase_sel = held_q ? phase_q : 4'd0;
		phase_inc = {1'b0, phase_sel} + 5'd1;
		period    = (cfg.repeat_ticks == 4'd0) ? 4'd1 : cfg.repeat_ticks;
		send      = 1'b0;
		payload   = bts_pkg::STARTUP_PAYLOAD;
		if (!startup_q) begin
			if (elapsed_n >= cfg.startup_limit) begin
				startup_n = 1'b1;
				send      = 1'b1;
			end
		end else if (pressed == 2'b00) begin
			held_n = 1'b0;
		end else begin
			held_n  = 1'b1;
			start_n = start_sel;
			phase_n = phase_sel;
			if (8'(sec_n - start_sel) < cfg.send_timeout_s) begin
				send    = (phase_sel == 4'd0);
				payload = {6'b000000, pressed};
				phase_n = (phase_inc >= {1'b0, period}) ? 4'd0 : phase_inc[3:0];
			end
		end
	end

	assign frm      = bts_pkg::build_frame(cfg.module_address, payload);
	assign adv      = valid_s1 && (!send || frm_free);
	assign frm_load = adv && send;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			buttons_s1 <= buttons_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q <= 1'b0;
			elapsed_q <= '0;
			tis_q     <= '0;
			sec_q     <= '0;
			held_q    <= 1'b0;
			start_q   <= '0;
			phase_q   <= '0;
		end else if (adv) begin
			startup_q <= startup_n;
			elapsed_q <= elapsed_n;
			tis_q     <= tis_n;
			sec_q     <= sec_n;
			held_q    <= held_n;
			start_q   <= start_n;
			phase_q   <= phase_n;
		end
	end

endmodule

// File: rtl/bts_frame.sv
// telegram byte serializer with output register
// depends on bts_pkg
module bts_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bts_pkg::frame_t       frm,
	input  logic                  frm_load,
	output logic                  frm_free,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            tx_byte,
	output logic                  last_byte
);

	logic [bts_pkg::FRAME_MAX-1:0][7:0] bytes_q;
	logic [bts_pkg::CNT_W-1:0]          cnt_q;
	logic                               out_valid_q;
	logic [7:0]                         tx_q;
	logic                               last_q;
	logic                               out_load;
	logic                               pop;

	assign out_load = !out_valid_q || !out_stall;
	assign pop      = out_load && (cnt_q != '0);
	assign frm_free = (cnt_q == '0) || ((cnt_q == 3'd1) && out_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frm_load) begin
				cnt_q <= frm.count;
			end else if (pop) begin
				cnt_q <= cnt_q - 3'd1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_load) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frm_load) begin
			bytes_q <= frm.bytes;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[bts_pkg::FRAME_MAX-1:1]};
		end
		if (pop) begin
			tx_q   <= bytes_q[0];
			last_q <= (cnt_q == 3'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_q;
	assign last_byte = last_q;

endmodule

// File: rtl/button_telegram_sender_core.sv
// top level of the button telegram sender
// depends on bts_pkg, bts_regs, bts_tick, bts_frame
//
// channel  signals                          handshake
// cfg      cfg_index, cfg_data              cfg_valid & cfg_ready
// in       buttons_n                        in_valid & !in_stall
// out      tx_byte, last_byte               out_valid & !out_stall
//
// a tick that sends nothing is taken every cycle
// a telegram is 4 to 7 bytes, one byte per cycle through the serializer while out_stall is low
// a tick that sends waits in the input register until the serializer is empty or moves its last byte out
// the first byte goes from the input register through the frame byte register into the output register
// arst_n clears control state and loads register defaults, data registers are not reset; cfg_ready is always high
module button_telegram_sender_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] buttons_n,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       last_byte
);

	bts_pkg::cfg_t   cfg;
	bts_pkg::frame_t frm;
	logic            frm_load;
	logic            frm_free;

	bts_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bts_tick u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.buttons_n (buttons_n),
		.frm       (frm),
		.frm_load  (frm_load),
		.frm_free  (frm_free)
	);

	bts_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm       (frm),
		.frm_load  (frm_load),
		.frm_free  (frm_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

endmodule

// File: rtl/bts_checker.sv
// port-level checker for the button telegram sender, bound to the top level
// depends on bts_pkg and button_telegram_sender_core_defines.svh
`include "button_telegram_sender_core_defines.svh"

module bts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] buttons_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	logic prev_last_q;
	logic prev_esc_q;

	// what the previous word on the line was
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
			prev_esc_q  <= 1'b0;
		end else if (out_valid && !out_stall) begin
			prev_last_q <= last_byte;
			prev_esc_q  <= (tx_byte == bts_pkg::FRAME_ESC);
		end
	end

	`BTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(tx_byte) && $stable(last_byte), "stalled word changed")

	`BTS_ASSERT_NOW(a_starts_stx, clk, arst_n, out_valid && prev_last_q,
		tx_byte == bts_pkg::FRAME_STX, "telegram does not start with stx")

	`BTS_ASSERT_NOW(a_esc_follow, clk, arst_n, out_valid && prev_esc_q,
		tx_byte == 8'hFD || tx_byte == 8'hE4, "bad word after escape")

	`BTS_ASSERT_NOW(a_no_esc_end, clk, arst_n, out_valid && last_byte,
		tx_byte != bts_pkg::FRAME_ESC && !prev_last_q, "telegram ends badly")

endmodule

bind button_telegram_sender_core bts_checker u_bts_checker (.*);
